/* rtl/osd_text_glyph_render_defines.svh */
// Assertion macros for the on-screen text generator checker.
// Included by otg_checker.sv; expects signals clk and rst_n in scope.
`ifndef OSD_TEXT_GLYPH_RENDER_DEFINES_SVH
`define OSD_TEXT_GLYPH_RENDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OTG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otg_checker: same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define OTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otg_checker: next-cycle implication violated");

`endif

/* rtl/otg_pkg.sv */
// Shared types, constants and font tables for the on-screen text generator.
// No dependencies; used by otg_mult and osd_text_glyph_render.
package otg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LINE_STRIDE  = 2'd2;

  // Register reset values.
  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [12:0] RST_LINE_STRIDE  = 13'd1920;

  // Magnification limits and span geometry.
  localparam logic [3:0] MAX_SCALE  = 4'd8;
  localparam logic [3:0] MIN_SCALE  = 4'd1;
  localparam int         MASK_W     = 40;
  localparam logic [5:0] MASK_BITS  = 6'd40;
  localparam int         GLYPH_COLS = 5;
  localparam logic [2:0] LAST_GLYPH_ROW = 3'd6;

  // Character codes recognized by the font lookup.
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_CASE_OFS = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PERIOD  = 8'h2e;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Font entry indexes.
  localparam logic [5:0] FI_DIGIT0  = 6'd26;
  localparam logic [5:0] FI_PERIOD  = 6'd36;
  localparam logic [5:0] FI_DASH    = 6'd37;
  localparam logic [5:0] FI_UNDER   = 6'd38;
  localparam logic [5:0] FI_COLON   = 6'd39;
  localparam logic [5:0] FI_SLASH   = 6'd40;
  localparam logic [5:0] FI_SPACE   = 6'd41;
  localparam logic [5:0] FI_UNKNOWN = 6'd42;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_BASE,
    ST_MUL_Y,
    ST_MUL_UV,
    ST_ADD_UV,
    ST_EMIT,
    ST_FINISH
  } state_t;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [12:0] a;
    logic [12:0] b;
  } mul_op_t;

  // 5x7 font; top glyph row in the most significant byte.
  localparam logic [55:0] FONT_ROM [0:42] = '{
    56'h000e010f110f00, 56'h10101e11111e00, 56'h000e1110110e00, 56'h01010f11110f00,
    56'h000e111f100e00, 56'h03040f04040400, 56'h000f110f010e00, 56'h10101e11111100,
    56'h04000c04040e00, 56'h02000602120c00, 56'h10121418141200, 56'h0c040404040e00,
    56'h001a1515151500, 56'h001e1111111100, 56'h000e1111110e00, 56'h001e111e101000,
    56'h000f110f010100, 56'h00161910101000, 56'h000f100e011e00, 56'h041f0404040300,
    56'h00111111130d00, 56'h001111110a0400, 56'h00111115150a00, 56'h00110a040a1100,
    56'h0011110f010e00, 56'h001f0204081f00, 56'h0e11131519110e, 56'h040c140404041f,
    56'h0e11010204081f, 56'h1e01010e01011e, 56'h02060a121f0202, 56'h1f10101e01011e,
    56'h0e10101e11110e, 56'h1f010204080808, 56'h0e11110e11110e, 56'h0e11110f01010e,
    56'h00000000000c0c, 56'h0000001f000000, 56'h0000000000001f, 56'h000c0c000c0c00,
    56'h01020408100000, 56'h00000000000000, 56'h000e1102040004
  };

  // Maps a character byte to its font entry, folding upper case to lower.
  function automatic logic [5:0] rom_index(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] idx;
    c = code;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      c = c + CH_CASE_OFS;
    end
    priority if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      idx = 6'(c - CH_LOWER_A);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      idx = FI_DIGIT0 + 6'(c - CH_ZERO);
    end else if (c == CH_PERIOD) begin
      idx = FI_PERIOD;
    end else if (c == CH_DASH) begin
      idx = FI_DASH;
    end else if (c == CH_UNDER) begin
      idx = FI_UNDER;
    end else if (c == CH_COLON) begin
      idx = FI_COLON;
    end else if (c == CH_SLASH) begin
      idx = FI_SLASH;
    end else if (c == CH_SPACE) begin
      idx = FI_SPACE;
    end else begin
      idx = FI_UNKNOWN;
    end
    return idx;
  endfunction

  // Returns the five pixels of one glyph row; bit 4 is the leftmost column.
  function automatic logic [4:0] font_row(input logic [5:0] idx, input logic [2:0] gy);
    logic [55:0] g;
    logic [5:0]  ofs;
    g   = (idx > FI_UNKNOWN) ? FONT_ROM[FI_UNKNOWN] : FONT_ROM[idx];
    ofs = {LAST_GLYPH_ROW - gy, 3'b000};
    return g[ofs +: 5];
  endfunction

endpackage

/* rtl/otg_mult.sv */
// Shared 13x13 multiplier with a registered product for the text generator.
// Depends on otg_pkg for the operand pair type.
module otg_mult (
  input  logic               clk,
  input  otg_pkg::mul_op_t   op,
  output logic [25:0]        prod_r
);

  // One product per cycle; the result is ready the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= 26'(op.a) * 26'(op.b);
  end

endmodule

/* rtl/osd_text_glyph_render.sv */
// On-screen text generator: turns characters into masked NV12 scanline spans.
// Depends on otg_pkg and instantiates otg_mult.
//
// Usage:
//   The input channel carries one character per transaction with its origin,
//   magnification, colour and an end-of-text flag. The output channel carries
//   one scanline span per transaction: luma and chroma row offsets, start
//   column, a 40-bit lit-pixel mask and the colour; last_row marks the final
//   span of a character. Frame width, height and stride are written on the
//   cfg_ port while the block is idle.
//   A drawn character is accepted in IDLE, then passes MUL_BASE, MUL_Y, MUL_UV
//   and ADD_UV, in which the shared multiplier forms the chroma plane base and
//   the two starting row offsets; EMIT loads one span per scanline (the luma
//   offset then advances by the stride each line, the chroma offset every
//   second line), and FINISH advances the cursor. A dropped character stays in
//   IDLE, one under bad geometry passes FINISH alone. in_stall is high while a
//   character is in work. A stall on the output holds the span register and
//   pauses the scanline sequencer. Reset restores the default 1920x1080
//   geometry and clears the cursor and the string state.
module osd_text_glyph_render (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  // Character input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic [11:0] in_start_x,
  input  logic [11:0] in_start_y,
  input  logic [3:0]  in_scale,
  input  logic [7:0]  in_luma,
  input  logic [7:0]  in_chroma_u,
  input  logic [7:0]  in_chroma_v,
  input  logic        in_end_of_text,
  // Scanline output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_y_row_addr,
  output logic [24:0] out_uv_row_addr,
  output logic [12:0] out_span_x,
  output logic [39:0] out_pixel_mask,
  output logic [7:0]  out_luma,
  output logic [7:0]  out_u,
  output logic [7:0]  out_v,
  output logic        out_last_row
);

  otg_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [12:0] fw_r, fh_r, stride_r;

  // String state
  logic [12:0] cursor_r;
  logic [11:0] top_r;
  logic        active_r, stopped_r;

  // Current character
  logic [5:0]  idx_r;
  logic [3:0]  s_r;
  logic [7:0]  luma_r, u_r, v_r;
  logic        eot_r;

  // Scanline walk
  logic [24:0] base_r;
  logic [23:0] ya_r;
  logic [24:0] ca_r;
  logic [12:0] row_r;
  logic [2:0]  gy_r, sub_r;
  logic [39:0] clip_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] o_ya_r;
  logic [24:0] o_ca_r;
  logic [12:0] o_x_r;
  logic [39:0] o_mask_r;
  logic [7:0]  o_luma_r, o_u_r, o_v_r;
  logic        o_last_r;

  // Shared multiplier
  otg_pkg::mul_op_t mul_op;
  logic [25:0]      prod_r;

  // Decode helpers
  logic        in_acc, stop_eff, geom_ok, load, last_span, in_frame;
  logic [3:0]  s_eff;
  logic [5:0]  six_s;
  logic [12:0] cursor_adv;
  logic [13:0] clip_diff;
  logic [5:0]  clip_n;
  logic [4:0]  glyph_bits;
  logic [39:0] low_mask, mask_raw;
  logic [5:0]  shamt;

  otg_mult u_mult (
    .clk    (clk),
    .op     (mul_op),
    .prod_r (prod_r)
  );

  // Handshake and item-level decode.
  assign in_acc   = in_valid && !in_stall;
  assign stop_eff = active_r && stopped_r;
  assign geom_ok  = (fw_r != 13'd0) && (fh_r != 13'd0) && (stride_r >= fw_r);
  assign s_eff    = (in_scale == 4'd0) ? otg_pkg::MIN_SCALE :
                    (in_scale > otg_pkg::MAX_SCALE) ? otg_pkg::MAX_SCALE : in_scale;
  assign six_s      = {s_r, 2'b00} + {1'b0, s_r, 1'b0};
  assign cursor_adv = cursor_r + 13'(six_s);
  assign last_span  = (gy_r == otg_pkg::LAST_GLYPH_ROW) && (sub_r == 3'(s_r - 4'd1));
  assign in_frame   = row_r < fh_r;

  // Clip length: columns left before the right frame edge, capped at the mask width.
  always_comb begin
    clip_diff = {1'b0, fw_r} - {1'b0, cursor_r};
    if (fw_r <= cursor_r) begin
      clip_n = 6'd0;
    end else if (clip_diff >= 14'(otg_pkg::MASK_BITS)) begin
      clip_n = otg_pkg::MASK_BITS;
    end else begin
      clip_n = clip_diff[5:0];
    end
  end

  // Horizontal expansion of the current glyph row by the scale.
  always_comb begin
    glyph_bits = otg_pkg::font_row(idx_r, gy_r);
    low_mask   = ~({otg_pkg::MASK_W{1'b1}} << s_r);
    mask_raw   = '0;
    shamt      = '0;
    for (int gx = 0; gx < otg_pkg::GLYPH_COLS; gx++) begin
      shamt = 6'(gx * s_r);
      if (glyph_bits[otg_pkg::GLYPH_COLS - 1 - gx]) begin
        mask_raw = mask_raw | (low_mask << shamt);
      end
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      otg_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (stop_eff) begin
            state_nxt = otg_pkg::ST_IDLE;
          end else if (geom_ok) begin
            state_nxt = otg_pkg::ST_MUL_BASE;
          end else begin
            state_nxt = otg_pkg::ST_FINISH;
          end
        end
      end
      otg_pkg::ST_MUL_BASE: state_nxt = otg_pkg::ST_MUL_Y;
      otg_pkg::ST_MUL_Y:    state_nxt = otg_pkg::ST_MUL_UV;
      otg_pkg::ST_MUL_UV:   state_nxt = otg_pkg::ST_ADD_UV;
      otg_pkg::ST_ADD_UV:   state_nxt = otg_pkg::ST_EMIT;
      otg_pkg::ST_EMIT: begin
        if (load && last_span) begin
          state_nxt = otg_pkg::ST_FINISH;
        end
      end
      otg_pkg::ST_FINISH:   state_nxt = otg_pkg::ST_IDLE;
      default:              state_nxt = otg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: input stall, span load and multiplier operands.
  always_comb begin
    in_stall = (state_r != otg_pkg::ST_IDLE);
    load     = (state_r == otg_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
    mul_op.a = stride_r;
    unique case (state_r)
      otg_pkg::ST_MUL_BASE: mul_op.b = fh_r;
      otg_pkg::ST_MUL_Y:    mul_op.b = {1'b0, top_r};
      otg_pkg::ST_MUL_UV:   mul_op.b = {2'b00, top_r[11:1]};
      default:              mul_op.b = '0;
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= otg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      fw_r        <= otg_pkg::RST_FRAME_WIDTH;
      fh_r        <= otg_pkg::RST_FRAME_HEIGHT;
      stride_r    <= otg_pkg::RST_LINE_STRIDE;
      cursor_r    <= '0;
      top_r       <= '0;
      active_r    <= 1'b0;
      stopped_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          otg_pkg::CFG_FRAME_WIDTH:  fw_r     <= cfg_wdata;
          otg_pkg::CFG_FRAME_HEIGHT: fh_r     <= cfg_wdata;
          otg_pkg::CFG_LINE_STRIDE:  stride_r <= cfg_wdata;
          default: ;
        endcase
      end

      // A character with no open string starts one at its own origin.
      if (in_acc) begin
        if (!active_r) begin
          cursor_r  <= {1'b0, in_start_x};
          top_r     <= in_start_y;
          active_r  <= 1'b1;
          stopped_r <= 1'b0;
        end else if (stop_eff && in_end_of_text) begin
          active_r  <= 1'b0;
          stopped_r <= 1'b0;
        end
      end

      // Cursor advance and stop check after a character; end of text closes the string.
      if (state_r == otg_pkg::ST_FINISH) begin
        cursor_r <= cursor_adv;
        if (eot_r) begin
          active_r  <= 1'b0;
          stopped_r <= 1'b0;
        end else begin
          stopped_r <= ({1'b0, cursor_adv} + 14'(six_s)) >= {1'b0, fw_r};
        end
      end
    end
  end

  // Character capture and scanline walk.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r  <= otg_pkg::rom_index(in_char_code);
      s_r    <= s_eff;
      luma_r <= in_luma;
      u_r    <= in_chroma_u;
      v_r    <= in_chroma_v;
      eot_r  <= in_end_of_text;
    end

    unique case (state_r)
      otg_pkg::ST_MUL_BASE: begin
        clip_r <= ~({otg_pkg::MASK_W{1'b1}} << clip_n);
        row_r  <= {1'b0, top_r};
        gy_r   <= '0;
        sub_r  <= '0;
      end
      otg_pkg::ST_MUL_Y:  base_r <= prod_r[24:0];
      otg_pkg::ST_MUL_UV: ya_r   <= prod_r[23:0];
      otg_pkg::ST_ADD_UV: ca_r   <= base_r + prod_r[24:0];
      otg_pkg::ST_EMIT: begin
        if (load) begin
          row_r <= row_r + 13'd1;
          ya_r  <= ya_r + 24'(stride_r);
          // The chroma row moves on when the luma row leaves an odd line.
          if (row_r[0]) begin
            ca_r <= ca_r + 25'(stride_r);
          end
          if (sub_r == 3'(s_r - 4'd1)) begin
            sub_r <= '0;
            gy_r  <= gy_r + 3'd1;
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Span register; rows below the frame carry no pixels and zero offsets.
  always_ff @(posedge clk) begin
    if (load) begin
      o_ya_r   <= in_frame ? ya_r : '0;
      o_ca_r   <= in_frame ? ca_r : '0;
      o_x_r    <= cursor_r;
      o_mask_r <= in_frame ? (mask_raw & clip_r) : '0;
      o_luma_r <= luma_r;
      o_u_r    <= u_r;
      o_v_r    <= v_r;
      o_last_r <= last_span;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_y_row_addr  = o_ya_r;
  assign out_uv_row_addr = o_ca_r;
  assign out_span_x      = o_x_r;
  assign out_pixel_mask  = o_mask_r;
  assign out_luma        = o_luma_r;
  assign out_u           = o_u_r;
  assign out_v           = o_v_r;
  assign out_last_row    = o_last_r;

endmodule

/* rtl/otg_checker.sv */
// Port-level checks for the on-screen text generator, bound to its top level.
// Depends on osd_text_glyph_render_defines.svh for the assertion macros.
`include "osd_text_glyph_render_defines.svh"

module otg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_y_row_addr,
  input logic [39:0] out_pixel_mask,
  input logic        out_last_row
);

  // Mask and row offset of the offered span, viewed as one word.
  logic [63:0] span_view;
  assign span_view = {out_pixel_mask, out_y_row_addr};

  // A stalled span stays offered.
  `OTG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled span keeps its mask and row offset.
  `OTG_ASSERT_NEXT(a_span_stable, out_valid && out_stall, $stable(span_view))

  // While a character still has rows to come, no new character is taken.
  `OTG_ASSERT_IMPL(a_busy_mid_char, out_valid && !out_last_row, in_stall)

  // Once a non-final span is taken, the next span of the character follows at once.
  `OTG_ASSERT_NEXT(a_rows_continue, out_valid && !out_stall && !out_last_row, out_valid)

endmodule

bind osd_text_glyph_render otg_checker u_otg_checker (.*);
